FILE: rtl/core/absolute_path_normalizer_core_assert.svh
// Assertion macros shared by the path normalizer RTL.
// Assertions compile out when SYNTHESIS is defined.
`ifndef ABSOLUTE_PATH_NORMALIZER_CORE_ASSERT_SVH
`define ABSOLUTE_PATH_NORMALIZER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Property must hold on every rising clock edge outside reset.
`define APN_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be true outside reset.
`define APN_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `APN_ASSERT(lbl, clk, rst_n, !(cond), msg)
`else
`define APN_ASSERT(lbl, clk, rst_n, prop, msg)
`define APN_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

FILE: rtl/core/apn_pkg.sv
package apn_pkg;

  // Default destination size, saturated to the 9-bit register range
  localparam int unsigned PATH_CAPACITY = 256;
  localparam logic [8:0]  CAP_RESET     = (PATH_CAPACITY > 511) ? 9'd511 : 9'(PATH_CAPACITY);

  localparam logic [7:0] SLASH = 8'h2F;
  localparam logic [7:0] DOT   = 8'h2E;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_ABS  = 2'd1,
    ST_PARENT   = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_e;

  // Results caused by one input word: up to four chars, then an optional status
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [2:0]      n_chars;
    status_e         status;
    logic            has_status;
  } entry_t;

endpackage

FILE: rtl/core/absolute_path_normalizer_core.sv
// Channel   Dir  Signals                           Payload
// s_axis    in   tvalid tready tdata tlast         tdata[7:0] ch, tlast is_end
// m_axis    out  tvalid tready tdata tuser tlast   tdata[7:0] out_char, [9:8] status,
//                                                  tuser char_valid, tlast last
// cfg       in   cfg_valid_i cfg_ready_o cfg_data_i out_capacity
//
// One input word per cycle; a word producing k results occupies k output words.
// The output sequencer (one result per cycle) sets the sustained rate; the two-entry
// queue between classifier and sequencer absorbs bursts, up to four results per entry.
// Reset (rst_ni low, async) empties the queue and returns to the start of a path.
// Input stalls only when the queue is full; output stalls back up into the queue.
module absolute_path_normalizer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  logic        s_axis_tlast,   // is_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_char, [9:8] status, [15:10] zero
  output logic        m_axis_tuser,   // [0] char_valid
  output logic        m_axis_tlast,   // last
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [8:0]  cfg_data_i      // out_capacity
);

  logic            push;
  logic            q_full;
  logic            q_valid;
  logic            q_pop;
  apn_pkg::entry_t push_entry;
  apn_pkg::entry_t q_entry;

  assign cfg_ready_o = 1'b1;

  apn_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_char_i   (s_axis_tdata),
    .in_end_i    (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  apn_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  apn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

FILE: rtl/core/apn_front.sv
module apn_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [7:0]     in_char_i,
  input  logic           in_end_i,
  output logic           in_ready_o,
  input  logic           cfg_valid_i,
  input  logic [8:0]     cfg_data_i,
  input  logic           q_full_i,
  output logic           push_o,
  output apn_pkg::entry_t entry_o
);

  logic                at_start_q, at_start_d;
  apn_pkg::status_e    err_q, err_d;
  logic [1:0]          cnt_q, cnt_d;
  logic [8:0]          len_q, len_d;
  logic [8:0]          cap_q;
  logic [1:0][7:0]     held_q;

  logic                accept;
  logic                hold_we;
  logic                close;
  logic                fin;
  logic                use_sep;
  logic [2:0][7:0]     pay;
  logic [2:0]          pay_n;
  logic [3:0][7:0]     chars;
  logic [2:0]          want;
  logic [2:0]          emit_n;
  logic signed [10:0]  avail;
  apn_pkg::status_e    stat;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Classify the word and work out which chars it releases
  always_comb begin
    at_start_d = at_start_q;
    err_d      = err_q;
    cnt_d      = cnt_q;
    hold_we    = 1'b0;
    close      = 1'b0;
    fin        = 1'b0;
    use_sep    = 1'b0;
    pay        = '0;
    pay_n      = 3'd0;

    if (in_end_i) begin
      fin = 1'b1;
      if (at_start_q) begin
        err_d = (cap_q == 9'd0) ? apn_pkg::ST_TOO_LONG : apn_pkg::ST_NOT_ABS;
      end else if (err_q == apn_pkg::ST_OK) begin
        close = 1'b1;
      end
    end else if (at_start_q) begin
      at_start_d = 1'b0;
      cnt_d      = 2'd0;
      if (cap_q == 9'd0) begin
        err_d = apn_pkg::ST_TOO_LONG;
      end else if (in_char_i != apn_pkg::SLASH) begin
        err_d = apn_pkg::ST_NOT_ABS;
      end
    end else if (err_q != apn_pkg::ST_OK) begin
      // dropped until the end word
    end else if (in_char_i == apn_pkg::SLASH) begin
      close = 1'b1;
      cnt_d = 2'd0;
    end else if (cnt_q < 2'd2) begin
      hold_we = 1'b1;
      cnt_d   = cnt_q + 2'd1;
    end else if (cnt_q == 2'd2) begin
      // component is now longer than "..": release held chars
      pay     = {in_char_i, held_q[1], held_q[0]};
      pay_n   = 3'd3;
      use_sep = 1'b1;
      cnt_d   = 2'd3;
    end else begin
      pay[0] = in_char_i;
      pay_n  = 3'd1;
    end

    // Closing a short component: drop ".", reject ".."
    if (close) begin
      if (cnt_q == 2'd1) begin
        if (held_q[0] != apn_pkg::DOT) begin
          pay[0]  = held_q[0];
          pay_n   = 3'd1;
          use_sep = 1'b1;
        end
      end else if (cnt_q == 2'd2) begin
        if (held_q[0] == apn_pkg::DOT && held_q[1] == apn_pkg::DOT) begin
          err_d = apn_pkg::ST_PARENT;
        end else begin
          pay[0]  = held_q[0];
          pay[1]  = held_q[1];
          pay_n   = 3'd2;
          use_sep = 1'b1;
        end
      end
    end

    // Separator goes first unless nothing has been written yet
    if (use_sep && len_q != 9'd0) begin
      chars = {pay[2], pay[1], pay[0], apn_pkg::SLASH};
      want  = pay_n + 3'd1;
    end else begin
      chars = {8'd0, pay};
      want  = pay_n;
    end

    // Capacity check: length must stay below out_capacity
    avail  = $signed({2'b00, cap_q}) - $signed({2'b00, len_q}) - 11'sd1;
    emit_n = want;
    if (want != 3'd0 && avail < $signed({8'd0, want})) begin
      emit_n = (avail < 11'sd0) ? 3'd0 : avail[2:0];
      err_d  = apn_pkg::ST_TOO_LONG;
    end
    len_d = len_q + {6'd0, emit_n};
    stat  = err_d;

    // End word starts a new path
    if (fin) begin
      at_start_d = 1'b1;
      err_d      = apn_pkg::ST_OK;
      cnt_d      = 2'd0;
      len_d      = 9'd0;
    end
  end

  assign push_o             = accept && (fin || emit_n != 3'd0);
  assign entry_o.chars      = chars;
  assign entry_o.n_chars    = emit_n;
  assign entry_o.status     = stat;
  assign entry_o.has_status = fin;

  // Path state and capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_start_q <= 1'b1;
      err_q      <= apn_pkg::ST_OK;
      cnt_q      <= 2'd0;
      len_q      <= 9'd0;
      cap_q      <= apn_pkg::CAP_RESET;
    end else begin
      if (accept) begin
        at_start_q <= at_start_d;
        err_q      <= err_d;
        cnt_q      <= cnt_d;
        len_q      <= len_d;
      end
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  // Held chars of the current component
  always_ff @(posedge clk_i) begin
    if (accept && hold_we) begin
      held_q[cnt_q[0]] <= in_char_i;
    end
  end

endmodule

FILE: rtl/core/apn_queue.sv
`include "absolute_path_normalizer_core_assert.svh"

module apn_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  apn_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output apn_pkg::entry_t entry_o
);

  localparam logic [apn_pkg::QCNT_W-1:0] DEPTH_C = apn_pkg::QCNT_W'(apn_pkg::QUEUE_DEPTH);
  localparam logic [apn_pkg::QPTR_W-1:0] LAST_C  = apn_pkg::QPTR_W'(apn_pkg::QUEUE_DEPTH - 1);

  apn_pkg::entry_t                  mem_q [apn_pkg::QUEUE_DEPTH];
  logic [apn_pkg::QPTR_W-1:0]       wr_q, rd_q;
  logic [apn_pkg::QCNT_W-1:0]       cnt_q;

  assign full_o  = (cnt_q == DEPTH_C);
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == LAST_C) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == LAST_C) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  `APN_ASSERT_NEVER(a_no_push_full, clk_i, rst_ni, push_i && full_o, "push into full queue")
  `APN_ASSERT_NEVER(a_no_pop_empty, clk_i, rst_ni, pop_i && !valid_o, "pop from empty queue")
  `APN_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= DEPTH_C, "queue count out of range")
  `APN_ASSERT(a_cnt_inc, clk_i, rst_ni, push_i && !pop_i |=> cnt_q == $past(cnt_q) + 1'b1, "queue count did not grow on push")

endmodule

FILE: rtl/core/apn_back.sv
module apn_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  apn_pkg::entry_t q_entry_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [15:0]     out_data_o,
  output logic            out_user_o,
  output logic            out_last_o
);

  apn_pkg::entry_t cur_q;
  logic            cur_vld_q;
  logic [1:0]      idx_q;

  logic [2:0]      total;
  logic            at_last;
  logic            fire;
  logic            is_char;

  // total results in the current entry is always 1..4
  assign total   = cur_q.n_chars + {2'b00, cur_q.has_status};
  assign at_last = ({1'b0, idx_q} == total - 3'd1);
  assign fire    = cur_vld_q && out_ready_i;
  assign q_pop_o = q_valid_i && (!cur_vld_q || (fire && at_last));

  // Step through the entry one word per cycle while the output is ready, load the next without a gap
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      idx_q     <= 2'd0;
    end else if (q_pop_o) begin
      cur_vld_q <= 1'b1;
      idx_q     <= 2'd0;
    end else if (fire) begin
      if (at_last) begin
        cur_vld_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_entry_i;
    end
  end

  // Char words first, then the status word
  assign is_char     = ({1'b0, idx_q} < cur_q.n_chars);
  assign out_valid_o = cur_vld_q;
  assign out_user_o  = is_char;
  assign out_last_o  = !is_char;
  assign out_data_o  = is_char ? {8'd0, cur_q.chars[idx_q]} : {6'd0, cur_q.status, 8'd0};

endmodule

FILE: test/absolute_path_normalizer_core_tb.sv
`timescale 1ns / 1ps

module absolute_path_normalizer_core_tb;

  // One output word of the normalizer
  typedef struct packed {
    logic [7:0]       ch;
    logic             is_char;
    logic             last;
    apn_pkg::status_e status;
  } norm_word_t;

  // Tracks the canonical path state and the output words still owed by the DUT
  class path_scoreboard;
    logic [8:0]       capacity;
    bit               at_start;
    apn_pkg::status_e err;
    logic [1:0]       seg_len;   // chars in current component, saturates at 3
    logic [7:0]       held [2];
    logic [8:0]       out_len;
    norm_word_t       owed_q[$];
    int               errors;

    function new();
      capacity = apn_pkg::CAP_RESET;
      errors   = 0;
      start_path();
    endfunction

    function void start_path();
      at_start = 1'b1;
      err      = apn_pkg::ST_OK;
      seg_len  = 2'd0;
      held[0]  = 8'h00;
      held[1]  = 8'h00;
      out_len  = 9'd0;
    endfunction

    function void set_capacity(logic [8:0] value);
      capacity = value;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void owe(logic [7:0] ch, logic is_char, logic last, apn_pkg::status_e status);
      norm_word_t w;
      w.ch      = ch;
      w.is_char = is_char;
      w.last    = last;
      w.status  = status;
      owed_q.push_back(w);
    endfunction

    // Output must stay strictly below capacity; first failure latches
    function void put_char(logic [7:0] ch);
      if (err != apn_pkg::ST_OK) return;
      if ({1'b0, out_len} + 10'd1 >= {1'b0, capacity}) begin
        err = apn_pkg::ST_TOO_LONG;
        return;
      end
      owe(ch, 1'b1, 1'b0, apn_pkg::ST_OK);
      out_len = out_len + 9'd1;
    endfunction

    function void put_separator();
      if (out_len != 9'd0) put_char(apn_pkg::SLASH);
    endfunction

    // Flush a short component held back at a slash or at the end of the path
    function void close_component();
      if (err != apn_pkg::ST_OK) return;
      if (seg_len == 2'd1) begin
        if (held[0] == apn_pkg::DOT) return;
        put_separator();
        put_char(held[0]);
      end else if (seg_len == 2'd2) begin
        if (held[0] == apn_pkg::DOT && held[1] == apn_pkg::DOT) begin
          err = apn_pkg::ST_PARENT;
          return;
        end
        put_separator();
        put_char(held[0]);
        put_char(held[1]);
      end
    endfunction

    // Advance the canonicalizer by one accepted input word
    function void note_word(logic [7:0] ch, logic is_end);
      if (is_end) begin
        if (at_start) err = (capacity == 9'd0) ? apn_pkg::ST_TOO_LONG : apn_pkg::ST_NOT_ABS;
        else close_component();
        owe(8'h00, 1'b0, 1'b1, err);
        start_path();
        return;
      end
      if (at_start) begin
        at_start = 1'b0;
        seg_len  = 2'd0;
        if (capacity == 9'd0) err = apn_pkg::ST_TOO_LONG;
        else if (ch != apn_pkg::SLASH) err = apn_pkg::ST_NOT_ABS;
        return;
      end
      if (err != apn_pkg::ST_OK) return;
      if (ch == apn_pkg::SLASH) begin
        close_component();
        seg_len = 2'd0;
      end else if (seg_len < 2'd2) begin
        held[seg_len[0]] = ch;
        seg_len = seg_len + 2'd1;
      end else if (seg_len == 2'd2) begin
        put_separator();
        put_char(held[0]);
        put_char(held[1]);
        put_char(ch);
        seg_len = 2'd3;
      end else begin
        put_char(ch);
      end
    endfunction

    // Compare one accepted output word against the oldest owed word
    function void check_word(logic [7:0] ch, logic is_char, logic last, logic [1:0] status);
      norm_word_t want;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected word ch=%h char_valid=%b last=%b status=%0d",
                 $time, ch, is_char, last, status);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (ch !== want.ch) begin
        $display("%0t: out_char expected %h actual %h", $time, want.ch, ch);
        errors++;
      end
      if (is_char !== want.is_char) begin
        $display("%0t: char_valid expected %b actual %b", $time, want.is_char, is_char);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: last expected %b actual %b", $time, want.last, last);
        errors++;
      end
      if (status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, status);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] ch
  logic        s_axis_tlast = 1'b0;    // is_end
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [7:0] out_char, [9:8] status
  logic        m_axis_tuser;           // [0] char_valid
  logic        m_axis_tlast;           // last
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [8:0]  cfg_data_i = 9'd0;      // out_capacity

  path_scoreboard sb = new();
  int unsigned src_idle_pct  = 11;
  int unsigned sink_idle_pct = 47;
  int          words_sent    = 0;
  bit          hold_mid_path = 1'b0;

  absolute_path_normalizer_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Output side: check accepted words, then pick next ready
  initial begin
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_word(m_axis_tdata[7:0], m_axis_tuser, m_axis_tlast, m_axis_tdata[9:8]);
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Present one input word, with random idle cycles ahead of it
  task automatic send_word(input logic [7:0] ch, input logic is_end);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= is_end;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_word(ch, is_end);
    words_sent++;
  endtask

  task automatic send_path(input string p, input bit close);
    for (int i = 0; i < p.len(); i++) send_word(p[i], 1'b0);
    if (close) send_word(8'($urandom), 1'b1);
  endtask

  // Stop sending, wait for every owed word, then let in-flight words settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [8:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_capacity(value);
  endtask

  // Dots are favored so '.', '..' and dotted names show up often
  function automatic logic [7:0] name_char();
    if ($urandom_range(4) == 0) return apn_pkg::DOT;
    return 8'($urandom_range(255));
  endfunction

  // Mostly well-formed absolute paths; some noise without a leading slash
  task automatic send_random_path();
    int n_comp;
    int kind;
    int len;
    if ($urandom_range(9) == 0) begin
      len = $urandom_range(0, 5);
      for (int i = 0; i < len; i++) send_word(8'($urandom_range(255)), 1'b0);
      send_word(8'($urandom), 1'b1);
      return;
    end
    send_word(apn_pkg::SLASH, 1'b0);
    n_comp = $urandom_range(0, 4);
    for (int c = 0; c < n_comp; c++) begin
      kind = $urandom_range(11);
      if (kind == 0) begin
        // empty component
      end else if (kind == 1) begin
        send_word(apn_pkg::DOT, 1'b0);
      end else if (kind == 2) begin
        send_word(apn_pkg::DOT, 1'b0);
        send_word(apn_pkg::DOT, 1'b0);
      end else begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) send_word(name_char(), 1'b0);
      end
      if (hold_mid_path) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        while (sb.pending() != 0) @(posedge clk_i);
        hold_mid_path = 1'b0;
      end
      if (c < n_comp - 1 || $urandom_range(3) == 0) send_word(apn_pkg::SLASH, 1'b0);
    end
    send_word(8'($urandom), 1'b1);
  endtask

  initial begin
    logic [8:0] caps [8];
    int         goal;
    caps = '{9'd256, 9'd3, 9'd17, 9'd1, 9'd255, 9'd64, 9'd200, 9'd256};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty path, not absolute, dot and zero/0xFF chars, parent, long name
    send_word(8'h5A, 1'b1);
    send_path("x", 1'b1);
    send_path("/./", 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'hA5, 1'b1);
    send_path("/../", 1'b1);
    send_path("/abc", 1'b1);
    wait_idle();

    // Zero capacity on a path and on an empty path
    write_capacity(9'd0);
    send_path("/", 1'b1);
    send_word(8'h00, 1'b1);
    wait_idle();

    // Length limit on the first and on the second emitted char
    write_capacity(9'd1);
    send_path("/a", 1'b1);
    wait_idle();
    write_capacity(9'd2);
    send_path("/ab", 1'b1);
    wait_idle();

    // Random phases; idle mix changes across them
    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 3) begin
        src_idle_pct  = 11;
        sink_idle_pct = 47;
      end else if (ph < 6) begin
        src_idle_pct  = 47;
        sink_idle_pct = 11;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      write_capacity(caps[ph]);
      if (ph == 1) hold_mid_path = 1'b1;
      goal = words_sent + 25;
      while (words_sent < goal) send_random_path();
      wait_idle();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("absolute_path_normalizer_core regression: pass");
    end else begin
      $display("absolute_path_normalizer_core regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(5_000_000);
    $display("absolute_path_normalizer_core regression: fail");
    $finish;
  end

endmodule
